// File: design/page_framebuffer_bar_fill_macros.svh
// Assertion helpers shared by the framebuffer fill block.
`ifndef PAGE_FRAMEBUFFER_BAR_FILL_MACROS_SVH
`define PAGE_FRAMEBUFFER_BAR_FILL_MACROS_SVH

// Checked only outside reset.
`define FBF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define FBF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/fbf_pkg.sv
package fbf_pkg;

  // Page index width that covers up to 128 rows
  localparam int PAGE_W = 4;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_SEND = 1'b1;

  localparam logic [2:0] PAGE_TOP_ROW = 3'd7;

  typedef enum logic [1:0] {
    STATUS_DRAWN  = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_SENT   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_PAGE,
    ST_READ,
    ST_WRITE,
    ST_SEND,
    ST_SEND_DATA,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       operation;
    logic [6:0] x_start;
    logic [5:0] y_start;
    logic [6:0] bar_width;
    logic [5:0] bar_height;
  } item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] pixel_byte;
    logic       frame_last;
  } result_t;

endpackage

// File: design/fbf_mem.sv
module fbf_mem
  import fbf_pkg::*;
#(
  parameter int DEPTH = 504,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/fbf_ctrl.sv
`include "page_framebuffer_bar_fill_macros.svh"

module fbf_ctrl
  import fbf_pkg::*;
#(
  parameter int COLUMNS = 84,
  parameter int ROWS    = 48,
  parameter int DEPTH   = 504,
  parameter int AW      = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  item_t         item,
  output logic          res_valid,
  input  logic          res_ready,
  output result_t       res,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [7:0]    mem_rdata
);

  state_t state, state_next;

  item_t             cur;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     base;
  logic [AW-1:0]     send_ptr;
  logic [PAGE_W-1:0] page;
  logic [PAGE_W-1:0] first_page;
  logic [PAGE_W-1:0] last_page;
  logic [7:0]        last_row;
  logic [6:0]        col_cnt;
  logic [7:0]        mask;

  logic [8:0] x_end;
  logic [7:0] y_end;
  logic       reject;
  logic       empty;
  logic       clear_mode;
  logic       send_last;
  logic [2:0] lo_bit;
  logic [2:0] hi_bit;
  logic [7:0] page_mask;

  assign x_end      = {2'b00, cur.x_start} + {2'b00, cur.bar_width};
  assign y_end      = {2'b00, cur.y_start} + {2'b00, cur.bar_height};
  assign reject     = ({2'b00, cur.x_start} >= 9'(COLUMNS)) ||
                      ({2'b00, cur.y_start} >= 8'(ROWS)) ||
                      (x_end > 9'(COLUMNS)) || (y_end > 8'(ROWS));
  assign empty      = (cur.bar_width == '0) || (cur.bar_height == '0);
  assign clear_mode = cur.y_start[0];
  assign first_page = {1'b0, cur.y_start[5:3]};
  assign last_page  = last_row[6:3];
  assign send_last  = (send_ptr == AW'(DEPTH - 1));

  // Rows of the bar that fall inside the current page
  assign lo_bit    = (page == first_page) ? cur.y_start[2:0] : 3'd0;
  assign hi_bit    = (page == last_page) ? last_row[2:0] : PAGE_TOP_ROW;
  assign page_mask = (8'hFF << lo_bit) & (8'hFF >> (PAGE_TOP_ROW - hi_bit));

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (cur_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (item.operation == OP_SEND) ? ST_SEND : ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = (reject || empty) ? ST_DONE : ST_PAGE;
      end
      ST_PAGE:      state_next = ST_READ;
      ST_READ:      state_next = ST_WRITE;
      ST_WRITE: begin
        if (col_cnt == 7'd1) begin
          state_next = (page == last_page) ? ST_DONE : ST_PAGE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_SEND:      state_next = ST_SEND_DATA;
      ST_SEND_DATA: state_next = ST_DONE;
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = '0;
    mem_raddr = cur_addr;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = clear_mode ? (mem_rdata & ~mask) : (mem_rdata | mask);
      end
      ST_SEND, ST_SEND_DATA: begin
        mem_raddr = send_ptr;
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cur_addr <= '0;
      send_ptr <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: begin
          if (cur_addr != AW'(DEPTH - 1)) begin
            cur_addr <= cur_addr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            cur <= item;
          end
        end
        ST_CHECK: begin
          res.pixel_byte <= '0;
          res.frame_last <= 1'b0;
          res.status     <= reject ? STATUS_REJECT : STATUS_DRAWN;
          page           <= first_page;
          last_row       <= y_end - 8'd1;
          base           <= AW'(32'(first_page) * COLUMNS);
        end
        ST_PAGE: begin
          cur_addr <= base + AW'(cur.x_start);
          col_cnt  <= cur.bar_width;
          mask     <= page_mask;
        end
        ST_WRITE: begin
          if (col_cnt == 7'd1) begin
            page <= page + PAGE_W'(1);
            base <= base + AW'(COLUMNS);
          end else begin
            cur_addr <= cur_addr + AW'(1);
            col_cnt  <= col_cnt - 7'd1;
          end
        end
        ST_SEND_DATA: begin
          res.status     <= STATUS_SENT;
          res.pixel_byte <= mem_rdata;
          res.frame_last <= send_last;
          send_ptr       <= send_last ? '0 : send_ptr + AW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  `FBF_ASSERT(a_write_follows_read, state == ST_WRITE |-> $past(state) == ST_READ, "write without a preceding read")
  `FBF_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready held after accept")
  `FBF_ASSERT_ALWAYS(a_send_ptr_range, rst || (send_ptr <= AW'(DEPTH - 1)), "send pointer out of range")
  `FBF_ASSERT(a_draw_addr_range, (state == ST_READ || state == ST_WRITE) |-> cur_addr <= AW'(DEPTH - 1), "draw address out of range")

endmodule

// File: design/page_framebuffer_bar_fill.sv
// Flow: a send transaction passes ST_SEND and ST_SEND_DATA before ST_DONE; a rejected
// or empty bar goes from ST_CHECK to ST_DONE; a drawn bar runs ST_PAGE for each page,
// then ST_READ and ST_WRITE for every covered byte, via the memory's read and write ports.
// One item at a time; the next is accepted once the output slot is free or m_tready high.
// Reset: synchronous; afterwards a clearing pass writes zero to all COLUMNS * pages
// bytes, one per cycle (504 bytes by default), and no item is accepted meanwhile.
module page_framebuffer_bar_fill
  import fbf_pkg::*;
#(
  parameter int COLUMNS = 84,
  parameter int ROWS    = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // x_start[6:0], y_start[12:7], bar_width[19:13], bar_height[25:20], zeros above
  input  logic [31:0] s_tdata,
  // operation[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], pixel_byte[9:2], zeros above
  output logic [15:0] m_tdata,
  output logic        m_tlast
);

  localparam int PAGES = (ROWS + 7) / 8;
  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);

  item_t         item;
  result_t       res;
  result_t       out_res;
  logic          res_valid;
  logic          res_ready;
  logic          out_valid;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  assign item.operation  = s_tuser;
  assign item.x_start    = s_tdata[6:0];
  assign item.y_start    = s_tdata[12:7];
  assign item.bar_width  = s_tdata[19:13];
  assign item.bar_height = s_tdata[25:20];

  fbf_ctrl #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS),
    .DEPTH  (DEPTH),
    .AW     (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .item     (item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  fbf_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Output register: take a result whenever the slot is empty or being drained
  assign res_ready = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b000000, out_res.pixel_byte, out_res.status};
  assign m_tlast  = out_res.frame_last;

endmodule
